// ===== design/bu2x_pkg.sv =====
// ----------------------------------------------------------------------------
// bu2x_pkg
// Shared types, sizes and helpers for the 2x bilinear upscaler.
// ----------------------------------------------------------------------------
package bu2x_pkg;

    localparam int MAX_WIDTH      = 1024;
    localparam int MAX_HEIGHT     = 1024;
    localparam int COMPONENT_BITS = 8;

    localparam int COL_BITS       = $clog2(MAX_WIDTH);
    localparam int ROW_BITS       = $clog2(MAX_HEIGHT);
    localparam int PIXEL_BITS     = 3 * COMPONENT_BITS;
    localparam int COORD_BITS     = 11;
    localparam int CFG_DATA_BITS  = 11;
    localparam int CFG_INDEX_BITS = 2;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SOURCE_WIDTH  = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SOURCE_HEIGHT = CFG_INDEX_BITS'(1);

    typedef logic [COMPONENT_BITS-1:0] comp_t;

    typedef struct packed {
        comp_t in_red;
        comp_t in_green;
        comp_t in_blue;
    } src_pixel_t;

    typedef struct packed {
        comp_t                 out_red;
        comp_t                 out_green;
        comp_t                 out_blue;
        logic [COORD_BITS-1:0] dest_row;
        logic [COORD_BITS-1:0] dest_col;
        logic                  last_of_run;
    } dst_pixel_t;

    typedef struct packed {
        comp_t red;
        comp_t green;
        comp_t blue;
    } rgb_t;

    // one destination column pair of an even row
    typedef struct packed {
        logic [COL_BITS-1:0] col;
        logic [ROW_BITS-1:0] row;
        rgb_t                left;
        rgb_t                right;
        logic                run_last;
    } pair_job_t;

    function automatic comp_t avg_comp(input comp_t a, input comp_t b);
        logic [COMPONENT_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COMPONENT_BITS:1];
    endfunction

    function automatic rgb_t avg_rgb(input rgb_t a, input rgb_t b);
        rgb_t r;
        r.red   = avg_comp(a.red, b.red);
        r.green = avg_comp(a.green, b.green);
        r.blue  = avg_comp(a.blue, b.blue);
        return r;
    endfunction

    // last valid index for a size register: zero reads as one, clamp at max
    function automatic int last_index(input logic [CFG_DATA_BITS-1:0] v, input int max_val);
        int n;
        n = int'(v);
        if (n == 0) begin
            return 0;
        end
        if (n > max_val) begin
            return max_val - 1;
        end
        return n - 1;
    endfunction

endpackage

// ===== design/bilinear_2x_upscaler.sv =====
// ----------------------------------------------------------------------------
// bilinear_2x_upscaler
// Path: front job registers, read stage, sequencing stage, output register.
// Throughput: one result per cycle from the sequencing stage while the sink
// is ready; a column pair gives 4 results (2 on the top source row).
// Reset: rst_n clears counters, size registers (1 x 1) and pipeline valids;
// the line store needs no clearing pass.
// ----------------------------------------------------------------------------
module bilinear_2x_upscaler (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration: index 0 source_width, index 1 source_height
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [bu2x_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [bu2x_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    // source pixels, raster order
    input  logic                                  src_valid,
    output logic                                  src_ready,
    input  bu2x_pkg::src_pixel_t                  src_pixel,
    // destination pixels with coordinates
    output logic                                  dst_valid,
    input  logic                                  dst_ready,
    output bu2x_pkg::dst_pixel_t                  dst_pixel
);

    import bu2x_pkg::*;

    // A source pixel turns into up to two column-pair jobs:
    //  - the pair of the previous pixel (needs this pixel as right neighbor)
    //  - its own pair when it is the last column (replicated)
    // Each job reads the line store (even/odd destination column RAMs)
    // at its column, forms the odd-row averages, and writes the new even
    // row values back. A back-to-back hit on the same column is forwarded
    // from the stage that is about to write.
    logic      job_valid;
    logic      job_ready;
    pair_job_t job;

    bu2x_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_pixel (src_pixel),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job)
    );

    // Read stage, sequencing stage and output register; the output
    // register holds a result until the sink takes it, and the pair in the
    // sequencing stage waits while it does.
    bu2x_pair u_pair (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .dst_valid (dst_valid),
        .dst_ready (dst_ready),
        .dst_pixel (dst_pixel)
    );

endmodule

// ===== design/bu2x_ram.sv =====
// ----------------------------------------------------------------------------
// bu2x_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bu2x_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/bu2x_front.sv =====
// ----------------------------------------------------------------------------
// bu2x_front
// Size registers, raster counters and column-pair job issue.
// ----------------------------------------------------------------------------
module bu2x_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [bu2x_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [bu2x_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  logic                                  src_valid,
    output logic                                  src_ready,
    input  bu2x_pkg::src_pixel_t                  src_pixel,
    output logic                                  job_valid,
    input  logic                                  job_ready,
    output bu2x_pkg::pair_job_t                   job
);

    import bu2x_pkg::*;

    logic [COL_BITS-1:0] width_last_reg,  width_last_next;
    logic [ROW_BITS-1:0] height_last_reg, height_last_next;
    logic [COL_BITS-1:0] col_reg,  col_next;
    logic [ROW_BITS-1:0] row_reg,  row_next;
    rgb_t                prev_reg, prev_next;

    // pending jobs of the held item: bit 0 left-neighbor pair, bit 1 last-column pair
    logic [1:0]          pend_reg, pend_next;
    logic [COL_BITS-1:0] f_col_reg, f_col_next;
    logic [ROW_BITS-1:0] f_row_reg, f_row_next;
    rgb_t                f_prev_reg, f_prev_next;
    rgb_t                f_avg_reg,  f_avg_next;
    rgb_t                f_cur_reg,  f_cur_next;

    logic                cfg_fire;
    logic                src_fire;
    logic                job_fire;
    logic                at_last_col;
    logic [1:0]          pend_after;
    rgb_t                cur;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    assign cur.red   = src_pixel.in_red;
    assign cur.green = src_pixel.in_green;
    assign cur.blue  = src_pixel.in_blue;

    assign at_last_col = col_reg >= width_last_reg;

    assign job_valid = pend_reg != 2'b00;
    assign job_fire  = job_valid && job_ready;

    always_comb
    begin
        if (pend_reg[0])
        begin
            job.col      = f_col_reg - COL_BITS'(1);
            job.left     = f_prev_reg;
            job.right    = f_avg_reg;
            job.run_last = !pend_reg[1];
        end
        else
        begin
            job.col      = f_col_reg;
            job.left     = f_cur_reg;
            job.right    = f_cur_reg;
            job.run_last = 1'b1;
        end
        job.row = f_row_reg;
    end

    always_comb
    begin
        pend_after = pend_reg;
        if (job_fire)
        begin
            if (pend_reg[0])
            begin
                pend_after[0] = 1'b0;
            end
            else
            begin
                pend_after[1] = 1'b0;
            end
        end
    end

    assign src_ready = pend_after == 2'b00;
    assign src_fire  = src_valid && src_ready;

    always_comb
    begin
        width_last_next  = width_last_reg;
        height_last_next = height_last_reg;
        if (cfg_fire)
        begin
            unique case (cfg_index)
                CFG_SOURCE_WIDTH:
                begin
                    width_last_next = COL_BITS'(last_index(cfg_data, MAX_WIDTH));
                end
                CFG_SOURCE_HEIGHT:
                begin
                    height_last_next = ROW_BITS'(last_index(cfg_data, MAX_HEIGHT));
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        col_next    = col_reg;
        row_next    = row_reg;
        prev_next   = prev_reg;
        pend_next   = pend_after;
        f_col_next  = f_col_reg;
        f_row_next  = f_row_reg;
        f_prev_next = f_prev_reg;
        f_avg_next  = f_avg_reg;
        f_cur_next  = f_cur_reg;
        if (src_fire)
        begin
            pend_next   = {at_last_col, col_reg != '0};
            f_col_next  = col_reg;
            f_row_next  = row_reg;
            f_prev_next = prev_reg;
            f_avg_next  = avg_rgb(prev_reg, cur);
            f_cur_next  = cur;
            prev_next   = cur;
            if (at_last_col)
            begin
                col_next = '0;
                row_next = (row_reg >= height_last_reg) ? '0 : row_reg + ROW_BITS'(1);
            end
            else
            begin
                col_next = col_reg + COL_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_last_reg  <= '0;
            height_last_reg <= '0;
            col_reg         <= '0;
            row_reg         <= '0;
            prev_reg        <= '0;
            pend_reg        <= 2'b00;
        end
        else
        begin
            width_last_reg  <= width_last_next;
            height_last_reg <= height_last_next;
            col_reg         <= col_next;
            row_reg         <= row_next;
            prev_reg        <= prev_next;
            pend_reg        <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        f_col_reg  <= f_col_next;
        f_row_reg  <= f_row_next;
        f_prev_reg <= f_prev_next;
        f_avg_reg  <= f_avg_next;
        f_cur_reg  <= f_cur_next;
    end

    // an item at column zero that is not the row end yields no pair
    a_no_job_first_col: assert property (@(posedge clk) disable iff (!rst_n)
        (src_fire && col_reg == '0 && !at_last_col) |=> (pend_reg == 2'b00))
        else $error("first-column item left a pending job");

    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg == 2'b00) |-> src_ready)
        else $error("no pending job but input not ready");

endmodule

// ===== design/bu2x_pair.sv =====
// ----------------------------------------------------------------------------
// bu2x_pair
// Line-store read/modify/write per column pair and result sequencing.
// ----------------------------------------------------------------------------
module bu2x_pair (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  job_valid,
    output logic                  job_ready,
    input  bu2x_pkg::pair_job_t   job,
    output logic                  dst_valid,
    input  logic                  dst_ready,
    output bu2x_pkg::dst_pixel_t  dst_pixel
);

    import bu2x_pkg::*;

    // read stage
    logic       s2_valid_reg, s2_valid_next;
    pair_job_t  s2_job_reg;
    logic       s2_fwd_reg;
    rgb_t       s2_fwd_left_reg;
    rgb_t       s2_fwd_right_reg;

    // sequencing stage
    logic       s3_valid_reg, s3_valid_next;
    pair_job_t  s3_job_reg;
    rgb_t       s3_odd_left_reg;
    rgb_t       s3_odd_right_reg;
    logic [1:0] s3_beat_reg, s3_beat_next;

    logic       out_valid_reg, out_valid_next;
    dst_pixel_t out_data_reg;
    dst_pixel_t out_next;

    logic       job_fire;
    logic       s2_move;
    logic       s3_free;
    logic       s3_final;
    logic       s3_last_beat;
    logic       out_load;
    logic       fwd_hit;

    rgb_t       even_rd;
    rgb_t       odd_rd;
    rgb_t       above_left;
    rgb_t       above_right;
    rgb_t       beat_pix;

    assign out_load     = s3_valid_reg && (!out_valid_reg || dst_ready);
    assign s3_last_beat = (s3_beat_reg == 2'd3) ||
                          (s3_beat_reg == 2'd1 && s3_job_reg.row == '0);
    assign s3_final     = out_load && s3_last_beat;
    assign s3_free      = !s3_valid_reg || s3_final;
    assign s2_move      = s2_valid_reg && s3_free;
    assign job_ready    = !s2_valid_reg || s2_move;
    assign job_fire     = job_valid && job_ready;

    // the only pair not yet written back is the one in the read stage
    assign fwd_hit = s2_valid_reg && (s2_job_reg.col == job.col);

    bu2x_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_even_col_ram (
        .clk     (clk),
        .wr_en   (s2_move),
        .wr_addr (s2_job_reg.col),
        .wr_data (s2_job_reg.left),
        .rd_en   (job_fire),
        .rd_addr (job.col),
        .rd_data (even_rd)
    );

    bu2x_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_odd_col_ram (
        .clk     (clk),
        .wr_en   (s2_move),
        .wr_addr (s2_job_reg.col),
        .wr_data (s2_job_reg.right),
        .rd_en   (job_fire),
        .rd_addr (job.col),
        .rd_data (odd_rd)
    );

    assign above_left  = s2_fwd_reg ? s2_fwd_left_reg  : even_rd;
    assign above_right = s2_fwd_reg ? s2_fwd_right_reg : odd_rd;

    assign s2_valid_next = job_fire ? 1'b1 : (s2_move ? 1'b0 : s2_valid_reg);
    assign s3_valid_next = s2_move  ? 1'b1 : (s3_final ? 1'b0 : s3_valid_reg);

    always_comb
    begin
        s3_beat_next = s3_beat_reg;
        if (s2_move)
        begin
            s3_beat_next = 2'd0;
        end
        else if (out_load)
        begin
            s3_beat_next = s3_beat_reg + 2'd1;
        end
    end

    always_comb
    begin
        unique case (s3_beat_reg)
            2'd0:    beat_pix = s3_job_reg.left;
            2'd1:    beat_pix = s3_job_reg.right;
            2'd2:    beat_pix = s3_odd_left_reg;
            default: beat_pix = s3_odd_right_reg;
        endcase
        out_next.out_red   = beat_pix.red;
        out_next.out_green = beat_pix.green;
        out_next.out_blue  = beat_pix.blue;
        if (s3_beat_reg[1])
        begin
            out_next.dest_row = COORD_BITS'({s3_job_reg.row - ROW_BITS'(1), 1'b1});
        end
        else
        begin
            out_next.dest_row = COORD_BITS'({s3_job_reg.row, 1'b0});
        end
        out_next.dest_col    = COORD_BITS'({s3_job_reg.col, s3_beat_reg[0]});
        out_next.last_of_run = s3_job_reg.run_last && s3_last_beat;
    end

    assign out_valid_next = out_load ? 1'b1 : (dst_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s3_beat_reg   <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            s3_beat_reg   <= s3_beat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_fire)
        begin
            s2_job_reg       <= job;
            s2_fwd_reg       <= fwd_hit;
            s2_fwd_left_reg  <= s2_job_reg.left;
            s2_fwd_right_reg <= s2_job_reg.right;
        end
        if (s2_move)
        begin
            s3_job_reg       <= s2_job_reg;
            s3_odd_left_reg  <= avg_rgb(above_left, s2_job_reg.left);
            s3_odd_right_reg <= avg_rgb(above_right, s2_job_reg.right);
        end
        if (out_load)
        begin
            out_data_reg <= out_next;
        end
    end

    assign dst_valid = out_valid_reg;
    assign dst_pixel = out_data_reg;

    a_top_row_two_beats: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && s3_job_reg.row == '0) |-> !s3_beat_reg[1])
        else $error("odd-row beat on the top source row");

    a_read_into_free: assert property (@(posedge clk) disable iff (!rst_n)
        (job_fire && s2_valid_reg) |-> s2_move)
        else $error("line-store read issued into an occupied stage");

    a_pair_starts_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        s2_move |=> (s3_valid_reg && s3_beat_reg == 2'd0))
        else $error("pair entered sequencing stage mid-run");

endmodule
